// ===== hdl/ufcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ufcc_pkg
// Shared types and constants for the disjoint-set cycle checker: command and
// result payloads, action codes and table widths.
// ----------------------------------------------------------------------------
package ufcc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VERT_W       = 5;
    localparam int CNT_W        = 6;
    localparam int RANK_W       = 3;
    localparam int ACT_W        = 2;

    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [VERT_W-1:0] vertex_a;
        logic [VERT_W-1:0] vertex_b;
    } cmd_t;

    typedef struct packed {
        logic same_set;
        logic bad_vertex;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/union_find_cycle_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_cycle_check
// Disjoint-set engine (union by rank, path compression) that reports whether
// a new edge closes a cycle, or whether two vertices share a set.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result
// appears on result for a single cycle with result_valid high, and the
// receiver must take it then. Clear, the ignored action and commands with a
// bad endpoint go from accept straight to a registered result. The next
// command can be taken in the result cycle. Add and query walk each
// endpoint's parent chain one table read per cycle through the parent
// table's single read port: a is walked to its root, then walked again to
// point each node on the path at that root, then b likewise; an add whose
// roots differ then links them. Depth is the number of parent hops to the
// root. When the sets were built from a clear over the current vertex count
// it is at most log2 of that count, and usually 0 or 1 after compression;
// raising the count without a clear can expose longer stale chains. For add
// and query, busy stays high until the result cycle.
// ----------------------------------------------------------------------------
module union_find_cycle_check (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire ufcc_pkg::cmd_t                      cmd,
    output logic                                     busy,
    output logic                                     result_valid,
    output ufcc_pkg::result_t                        result,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ufcc_pkg::CNT_W-1:0]          cfg_wr_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FIND = 4'b0010,
        ST_COMP = 4'b0100,
        ST_LINK = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [ufcc_pkg::CNT_W-1:0]          nv_reg;
    logic [ufcc_pkg::ACT_W-1:0]          action_reg, action_next;
    logic [ufcc_pkg::VERT_W-1:0]         vb_reg, vb_next;
    logic [ufcc_pkg::VERT_W-1:0]         cur_reg, cur_next;
    logic [ufcc_pkg::VERT_W-1:0]         start_v_reg, start_v_next;
    logic [ufcc_pkg::VERT_W-1:0]         root_reg, root_next;
    logic [ufcc_pkg::VERT_W-1:0]         root_a_reg, root_a_next;
    logic [ufcc_pkg::RANK_W-1:0]         rank_a_reg, rank_a_next;
    logic                                side_reg, side_next;
    logic                                valid_reg, valid_next;
    ufcc_pkg::result_t                   res_reg, res_next;

    logic [ufcc_pkg::VERT_W-1:0]         parent_reg [ufcc_pkg::MAX_VERTICES];
    logic [ufcc_pkg::RANK_W-1:0]         rank_reg   [ufcc_pkg::MAX_VERTICES];

    logic                                clr_en;
    logic                                par_we;
    logic [ufcc_pkg::VERT_W-1:0]         par_waddr;
    logic [ufcc_pkg::VERT_W-1:0]         par_wdata;
    logic                                rank_we;
    logic [ufcc_pkg::RANK_W-1:0]         rank_wdata;

    logic [ufcc_pkg::CNT_W-1:0]          count;
    logic [ufcc_pkg::VERT_W-1:0]         par_rd;
    logic [ufcc_pkg::RANK_W-1:0]         rank_rd;
    logic                                accept;
    logic                                bad;

    // Clamp the vertex count to the table depth
    assign count = (nv_reg > ufcc_pkg::CNT_W'(ufcc_pkg::MAX_VERTICES))
                 ? ufcc_pkg::CNT_W'(ufcc_pkg::MAX_VERTICES) : nv_reg;

    // Single read port of each table
    assign par_rd  = parent_reg[cur_reg];
    assign rank_rd = rank_reg[root_reg];

    assign accept = start && (state_reg == ST_IDLE);
    assign bad    = ({1'b0, cmd.vertex_a} >= count) || ({1'b0, cmd.vertex_b} >= count);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        action_next  = action_reg;
        vb_next      = vb_reg;
        cur_next     = cur_reg;
        start_v_next = start_v_reg;
        root_next    = root_reg;
        root_a_next  = root_a_reg;
        rank_a_next  = rank_a_reg;
        side_next    = side_reg;
        valid_next   = 1'b0;
        res_next     = '0;
        clr_en       = 1'b0;
        par_we       = 1'b0;
        par_waddr    = cur_reg;
        par_wdata    = root_reg;
        rank_we      = 1'b0;
        rank_wdata   = rank_rd + ufcc_pkg::RANK_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_next = cmd.action;
                    vb_next     = cmd.vertex_b;
                    if (cmd.action == ufcc_pkg::ACT_CLEAR)
                    begin
                        clr_en     = 1'b1;
                        valid_next = 1'b1;
                    end
                    else if (cmd.action == ufcc_pkg::ACT_NOP)
                    begin
                        valid_next = 1'b1;
                    end
                    else if (bad)
                    begin
                        valid_next          = 1'b1;
                        res_next.bad_vertex = 1'b1;
                    end
                    else
                    begin
                        cur_next     = cmd.vertex_a;
                        start_v_next = cmd.vertex_a;
                        side_next    = 1'b0;
                        state_next   = ST_FIND;
                    end
                end
            end

            ST_FIND:
            begin
                // Walk up one parent per cycle until a self-parent is found
                if (par_rd == cur_reg)
                begin
                    root_next  = cur_reg;
                    cur_next   = start_v_reg;
                    state_next = ST_COMP;
                end
                else
                begin
                    cur_next = par_rd;
                end
            end

            ST_COMP:
            begin
                if (cur_reg == root_reg)
                begin
                    if (!side_reg)
                    begin
                        // Hold the first root and its rank, then find the second
                        root_a_next  = root_reg;
                        rank_a_next  = rank_rd;
                        side_next    = 1'b1;
                        cur_next     = vb_reg;
                        start_v_next = vb_reg;
                        state_next   = ST_FIND;
                    end
                    else if (root_a_reg == root_reg)
                    begin
                        valid_next        = 1'b1;
                        res_next.same_set = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    else if (action_reg == ufcc_pkg::ACT_ADD)
                    begin
                        state_next = ST_LINK;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // Point this node at the root and advance along the old link
                    par_we   = 1'b1;
                    cur_next = par_rd;
                end
            end

            ST_LINK:
            begin
                // Union by rank: root_a is x, root_reg is y
                par_we     = 1'b1;
                valid_next = 1'b1;
                state_next = ST_IDLE;
                if (rank_a_reg > rank_rd)
                begin
                    par_waddr = root_reg;
                    par_wdata = root_a_reg;
                end
                else
                begin
                    par_waddr = root_a_reg;
                    par_wdata = root_reg;
                    rank_we   = (rank_a_reg == rank_rd) && (rank_rd < ufcc_pkg::RANK_MAX);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            nv_reg    <= ufcc_pkg::CNT_W'(ufcc_pkg::MAX_VERTICES);
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_wr_en)
            begin
                nv_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        vb_reg      <= vb_next;
        cur_reg     <= cur_next;
        start_v_reg <= start_v_next;
        root_reg    <= root_next;
        root_a_reg  <= root_a_next;
        rank_a_reg  <= rank_a_next;
        side_reg    <= side_next;
        res_reg     <= res_next;
    end

    // Parent and rank tables; clear resets every entry below the count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ufcc_pkg::MAX_VERTICES; i++)
            begin
                parent_reg[i] <= ufcc_pkg::VERT_W'(i);
                rank_reg[i]   <= '0;
            end
        end
        else if (clr_en)
        begin
            for (int i = 0; i < ufcc_pkg::MAX_VERTICES; i++)
            begin
                if (ufcc_pkg::CNT_W'(i) < count)
                begin
                    parent_reg[i] <= ufcc_pkg::VERT_W'(i);
                    rank_reg[i]   <= '0;
                end
            end
        end
        else
        begin
            if (par_we)
            begin
                parent_reg[par_waddr] <= par_wdata;
            end
            if (rank_we)
            begin
                rank_reg[root_reg] <= rank_wdata;
            end
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire
